@@ hdl/segment_reorder_buffer_core_assert.svh @@
// Assertion macros for the segment reorder buffer.
// Included by the top level; expects clk and rst_n in scope at the point of use.
`ifndef SEGMENT_REORDER_BUFFER_CORE_ASSERT_SVH
`define SEGMENT_REORDER_BUFFER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define SRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define SRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRB_ASSERT(lbl, prop, msg)
`define SRB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/srb_pkg.sv @@
// Shared types and constants of the segment reorder buffer.
// No dependencies.
package srb_pkg;

  localparam int SEQ_W            = 32;
  localparam int LEN_W            = 16;
  localparam int STATUS_W         = 3;
  localparam int DEF_BUFFER_DEPTH = 16;
  localparam int DEF_HANDLE_BITS  = 8;
  localparam int MAX_RESULTS      = 16;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;

  localparam logic [0:0] CMD_INSERT = 1'b0;
  localparam logic [0:0] CMD_DRAIN  = 1'b1;

  localparam logic [0:0] REG_INIT_SEQ = 1'b0;

  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STALE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

  typedef enum logic [1:0] {
    OSRC_INSERT,
    OSRC_PEND,
    OSRC_EMPTY
  } out_src_t;

  typedef struct packed {
    logic     latch_in;
    logic     drain_sel;
    logic     ins_commit;
    logic     rd_issue;
    logic     dlv_commit;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
  } srb_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } srb_stat_t;

endpackage

@@ hdl/srb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/srb_ctrl.sv @@
// Sequencer of the segment reorder buffer: input handshake, insert and drain steps.
// Depends on srb_pkg.
module srb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  srb_pkg::srb_stat_t stat,
  output srb_pkg::srb_cmd_t  cmd
);

  localparam int CNT_W = $clog2(srb_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_SRCH,
    S_DLV
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             more;

  assign in_ready = (state_r == S_IDLE);
  assign more     = stat.hit && (cnt_r < CNT_W'(srb_pkg::MAX_RESULTS));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.out_src    = srb_pkg::OSRC_INSERT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = (in_command == srb_pkg::CMD_DRAIN) ? S_SRCH : S_INS;
        end
      end
      S_INS: begin
        if (stat.out_free) begin
          cmd.ins_commit = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_src    = srb_pkg::OSRC_INSERT;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SRCH: begin
        cmd.drain_sel = 1'b1;
        if (more) begin
          // the held beat is known not to be the last one
          if (cnt_r == '0 || stat.out_free) begin
            cmd.out_load = (cnt_r != '0);
            cmd.out_src  = srb_pkg::OSRC_PEND;
            cmd.rd_issue = 1'b1;
            state_nxt    = S_DLV;
          end
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = (cnt_r == '0) ? srb_pkg::OSRC_EMPTY : srb_pkg::OSRC_PEND;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DLV: begin
        cmd.dlv_commit = 1'b1;
        cnt_nxt        = cnt_r + CNT_W'(1);
        state_nxt      = S_SRCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/srb_dp.sv @@
// Datapath of the segment reorder buffer: entry store, expected sequence,
// parallel compares and the output register. Depends on srb_pkg and srb_ram.
module srb_dp #(
  parameter int BUFFER_DEPTH = srb_pkg::DEF_BUFFER_DEPTH,
  parameter int HANDLE_BITS  = srb_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srb_pkg::srb_cmd_t             cmd,
  output srb_pkg::srb_stat_t            stat,
  input  logic [srb_pkg::SEQ_W-1:0]     in_segment_seq,
  input  logic [srb_pkg::LEN_W-1:0]     in_segment_length,
  input  logic [HANDLE_BITS-1:0]        in_payload_handle,
  input  logic                          cfg_we,
  input  logic [srb_pkg::SEQ_W-1:0]     cfg_wdata,
  output logic [srb_pkg::SEQ_W-1:0]     init_seq,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [srb_pkg::STATUS_W-1:0]  out_status,
  output logic [srb_pkg::SEQ_W-1:0]     out_seq,
  output logic [srb_pkg::LEN_W-1:0]     out_length,
  output logic [HANDLE_BITS-1:0]        out_handle,
  output logic [srb_pkg::SEQ_W-1:0]     out_next_expected,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int RAM_W = srb_pkg::LEN_W + HANDLE_BITS;

  logic [srb_pkg::SEQ_W-1:0]    init_seq_r;
  logic [srb_pkg::SEQ_W-1:0]    exp_r;
  logic [BUFFER_DEPTH-1:0]      ent_vld_r;
  logic [srb_pkg::SEQ_W-1:0]    ent_seq_r [BUFFER_DEPTH];
  logic [srb_pkg::SEQ_W-1:0]    in_seq_r;
  logic [srb_pkg::LEN_W-1:0]    in_len_r;
  logic [HANDLE_BITS-1:0]       in_hd_r;
  logic [IDX_W-1:0]             idx_r;
  logic [srb_pkg::SEQ_W-1:0]    pend_seq_r;
  logic [srb_pkg::LEN_W-1:0]    pend_len_r;
  logic [HANDLE_BITS-1:0]       pend_hd_r;
  logic                         out_valid_r;
  logic [srb_pkg::STATUS_W-1:0] out_status_r;
  logic [srb_pkg::SEQ_W-1:0]    out_seq_r;
  logic [srb_pkg::LEN_W-1:0]    out_len_r;
  logic [HANDLE_BITS-1:0]       out_hd_r;
  logic [srb_pkg::SEQ_W-1:0]    out_next_r;
  logic                         out_last_r;

  logic [srb_pkg::SEQ_W-1:0]    cmp_val;
  logic [BUFFER_DEPTH-1:0]      eq_vec;
  logic [BUFFER_DEPTH-1:0]      lt_vec;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             free_idx;
  logic [srb_pkg::STATUS_W-1:0] ins_status;
  logic                         ins_store;
  logic [RAM_W-1:0]             ram_rdata;
  logic [srb_pkg::LEN_W-1:0]    rd_len;
  logic [HANDLE_BITS-1:0]       rd_hd;

  // one bank of comparators serves both the duplicate check and the drain match
  assign cmp_val = cmd.drain_sel ? exp_r : in_seq_r;

  always_comb begin
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      eq_vec[i] = ent_vld_r[i] && (ent_seq_r[i] == cmp_val);
      lt_vec[i] = ent_vld_r[i] && (ent_seq_r[i] < exp_r);
    end
  end

  // lowest index wins in both encoders
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = BUFFER_DEPTH - 1; i >= 0; i--) begin
      if (eq_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!ent_vld_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // the head is the smallest stored sequence; it is deliverable only if it
  // equals the expected value, so no stored entry may lie below it
  assign stat.hit      = (|eq_vec) && !(|lt_vec);
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    if (in_seq_r < exp_r) begin
      ins_status = srb_pkg::ST_STALE;
    end else if (|eq_vec) begin
      ins_status = srb_pkg::ST_DUP;
    end else if (&ent_vld_r) begin
      ins_status = srb_pkg::ST_FULL;
    end else begin
      ins_status = srb_pkg::ST_STORED;
    end
  end

  assign ins_store = cmd.ins_commit && (ins_status == srb_pkg::ST_STORED);

  srb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ins_store),
    .waddr (free_idx),
    .wdata ({in_len_r, in_hd_r}),
    .re    (cmd.rd_issue),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  assign rd_len = ram_rdata[RAM_W-1 -: srb_pkg::LEN_W];
  assign rd_hd  = ram_rdata[HANDLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_seq_r  <= '0;
      exp_r       <= '0;
      ent_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_seq_r <= cfg_wdata;
        exp_r      <= cfg_wdata;
      end else if (cmd.dlv_commit) begin
        exp_r <= exp_r + srb_pkg::SEQ_W'(rd_len);
      end
      if (ins_store) begin
        ent_vld_r[free_idx] <= 1'b1;
      end
      if (cmd.dlv_commit) begin
        ent_vld_r[idx_r] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_seq_r <= in_segment_seq;
      in_len_r <= in_segment_length;
      in_hd_r  <= in_payload_handle;
    end
    if (ins_store) begin
      ent_seq_r[free_idx] <= in_seq_r;
    end
    if (cmd.rd_issue) begin
      idx_r <= hit_idx;
    end
    // hold the delivered segment until the next search says whether it is last
    if (cmd.dlv_commit) begin
      pend_seq_r <= exp_r;
      pend_len_r <= rd_len;
      pend_hd_r  <= rd_hd;
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      out_next_r <= exp_r;
      case (cmd.out_src)
        srb_pkg::OSRC_INSERT: begin
          out_status_r <= ins_status;
          out_seq_r    <= in_seq_r;
          out_len_r    <= '0;
          out_hd_r     <= in_hd_r;
        end
        srb_pkg::OSRC_PEND: begin
          out_status_r <= srb_pkg::ST_DELIVERED;
          out_seq_r    <= pend_seq_r;
          out_len_r    <= pend_len_r;
          out_hd_r     <= pend_hd_r;
        end
        default: begin
          out_status_r <= srb_pkg::ST_NONE;
          out_seq_r    <= '0;
          out_len_r    <= '0;
          out_hd_r     <= '0;
        end
      endcase
    end
  end

  assign init_seq          = init_seq_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_seq           = out_seq_r;
  assign out_length        = out_len_r;
  assign out_handle        = out_hd_r;
  assign out_next_expected = out_next_r;
  assign out_last          = out_last_r;

endmodule

@@ hdl/segment_reorder_buffer_core.sv @@
// Segment reorder buffer: an insert is accepted and its beat captured, then it
// is checked against every stored entry in parallel and stored once the output
// register is free. A drain captures its beat, then for each delivered segment
// runs a parallel match of the expected sequence against all entries, then
// a registered read of the length and handle store, and closes with the
// final search that ends it; at most 16 segments leave per drain. The next
// input beat is taken once the previous command has finished, while its last
// result may still wait in the output register. Sequence compares are plain
// unsigned; the expected value advances by each delivered length modulo 2^32.
// Depends on srb_pkg, srb_ctrl, srb_dp, srb_ram and the assertion header.
`include "segment_reorder_buffer_core_assert.svh"

module segment_reorder_buffer_core #(
  parameter int BUFFER_DEPTH = srb_pkg::DEF_BUFFER_DEPTH,
  parameter int HANDLE_BITS  = srb_pkg::DEF_HANDLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [srb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [srb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [srb_pkg::SEQ_W-1:0]       in_segment_seq,
  input  logic [srb_pkg::LEN_W-1:0]       in_segment_length,
  input  logic [HANDLE_BITS-1:0]          in_payload_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [srb_pkg::STATUS_W-1:0]    out_status,
  output logic [srb_pkg::SEQ_W-1:0]       out_seq,
  output logic [srb_pkg::LEN_W-1:0]       out_length,
  output logic [HANDLE_BITS-1:0]          out_handle,
  output logic [srb_pkg::SEQ_W-1:0]       out_next_expected,
  output logic                            out_last
);

  srb_pkg::srb_cmd_t  cmd;
  srb_pkg::srb_stat_t stat;
  logic [0:0]                 reg_idx;
  logic                       cfg_we;
  logic [srb_pkg::SEQ_W-1:0]  init_seq;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2 +: 1];
  assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == srb_pkg::REG_INIT_SEQ);
  assign prdata  = (reg_idx == srb_pkg::REG_INIT_SEQ) ? init_seq : '0;

  srb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  srb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_segment_seq    (in_segment_seq),
    .in_segment_length (in_segment_length),
    .in_payload_handle (in_payload_handle),
    .cfg_we            (cfg_we),
    .cfg_wdata         (pwdata),
    .init_seq          (init_seq),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_seq           (out_seq),
    .out_length        (out_length),
    .out_handle        (out_handle),
    .out_next_expected (out_next_expected),
    .out_last          (out_last)
  );

  `SRB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && in_ready), "reset left block busy")
  `SRB_ASSERT(a_insert_two_cycles, (in_valid && in_ready && in_command == srb_pkg::CMD_INSERT && !out_valid) |=> ##1 (out_valid && out_last), "insert result late")
  `SRB_ASSERT(a_single_result_last, (out_valid && out_status != srb_pkg::ST_DELIVERED) |-> out_last, "single result not marked last")
  `SRB_ASSERT(a_deliver_advance, (out_valid && out_status == srb_pkg::ST_DELIVERED) |-> (out_next_expected == out_seq + srb_pkg::SEQ_W'(out_length)), "expected sequence advanced wrongly")

endmodule
